/* hw/rtl/gha_pkg.sv */
// Shared types, command and status codes for the generational handle allocator.
// Used by gha_exec, generational_handle_allocator_core and the testbench; depends on nothing.
package gha_pkg;

  localparam int SLOT_COUNT_DEF = 1024;
  localparam int GEN_BITS_DEF   = 32;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int HGEN_W   = 32;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  // Decision for one command, from the execute stage to the state update.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                alive;
    logic                slot_we;
    logic                slot_live;
    logic                push;
    logic                pop;
    logic                fresh;
  } gha_ctrl_t;

endpackage

/* hw/rtl/gha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/gha_exec.sv */
// Execute-stage decision logic: handle match, generation bump, allocate source.
// Depends on gha_pkg.
module gha_exec #(
  parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF,
  localparam int IDX_W     = $clog2(SLOT_COUNT),
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1)
) (
  input  logic [gha_pkg::CMD_W-1:0]  cmd,
  input  logic [IDX_W-1:0]           idx,
  input  logic [gha_pkg::HGEN_W-1:0] hgen,
  input  logic                       slot_live,
  input  logic [GEN_BITS-1:0]        slot_gen,
  input  logic [CNT_W-1:0]           cnt,
  input  logic [CNT_W-1:0]           next_fresh,
  output gha_pkg::gha_ctrl_t         ctrl,
  output logic [GEN_BITS-1:0]        new_gen
);

  logic                match;
  logic [GEN_BITS-1:0] gen_inc;

  // Generation bits above GEN_BITS make a handle stale.
  assign match = (idx != '0) && (CNT_W'(idx) < next_fresh) && slot_live &&
                 ((hgen >> GEN_BITS) == '0) && (hgen[GEN_BITS-1:0] == slot_gen);

  // Bump the generation, skip zero on wrap.
  assign gen_inc = slot_gen + GEN_BITS'(1);
  assign new_gen = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

  always_comb begin
    ctrl        = '0;
    ctrl.status = gha_pkg::ST_INVALID;
    case (cmd)
      gha_pkg::CMD_ALLOC: begin
        if (cnt != '0) begin
          ctrl.pop = 1'b1;
        end else if (next_fresh < CNT_W'(SLOT_COUNT)) begin
          ctrl.fresh = 1'b1;
        end
        if (ctrl.pop || ctrl.fresh) begin
          ctrl.status    = gha_pkg::ST_OK;
          ctrl.slot_we   = 1'b1;
          ctrl.slot_live = 1'b1;
        end else begin
          ctrl.status = gha_pkg::ST_FULL;
        end
      end
      gha_pkg::CMD_CHECK: begin
        if (match) begin
          ctrl.status = gha_pkg::ST_OK;
          ctrl.alive  = 1'b1;
        end
      end
      gha_pkg::CMD_RELEASE: begin
        if (match && (cnt < CNT_W'(SLOT_COUNT))) begin
          ctrl.status  = gha_pkg::ST_OK;
          ctrl.slot_we = 1'b1;
          ctrl.push    = 1'b1;
        end
      end
      default: begin
        ctrl.status = gha_pkg::ST_INVALID;
      end
    endcase
  end

endmodule

/* hw/rtl/generational_handle_allocator_core.sv */
// Top level of the generational handle allocator: state, RAMs, forwarding.
// Depends on gha_pkg, gha_ram and gha_exec.
//
//   channel  | direction | handshake                 | words
//   ---------+-----------+---------------------------+-------------------------------------
//   command  | in        | start high, busy low      | command, handle_index,
//            |           |                           | handle_generation
//   result   | out       | done high for one cycle   | status, out_index, out_generation,
//            |           |                           | is_alive
//
// One word is taken every cycle; it is registered into the execute stage, and its
// result is registered from there into the outputs with done. The rate is set by one
// read-modify-write of the slot RAM and one free-stack access per word, with
// forwarding from the execute stage to the word being read behind it. busy stays
// low. Reset clears the counters and valid flags only: slots at or above the fresh
// index read as unused, and a fresh allocate writes the slot's initial generation,
// so the RAMs need no clearing pass. The receiver cannot stall.
module generational_handle_allocator_core #(
  parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF,
  localparam int IDX_W     = $clog2(SLOT_COUNT),
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [gha_pkg::CMD_W-1:0]    command,
  input  logic [IDX_W-1:0]             handle_index,
  input  logic [gha_pkg::HGEN_W-1:0]   handle_generation,
  output logic                         done,
  output logic [gha_pkg::STATUS_W-1:0] status,
  output logic [IDX_W-1:0]             out_index,
  output logic [gha_pkg::HGEN_W-1:0]   out_generation,
  output logic                         is_alive
);

  localparam int SLOT_W = GEN_BITS + 1;     // {live, generation}
  localparam int STK_W  = IDX_W + GEN_BITS; // {index, generation}

  // Committed state.
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] next_fresh;
  logic [CNT_W-1:0] next_fresh_next;

  // Execute-stage word.
  logic                       s1_valid;
  logic [gha_pkg::CMD_W-1:0]  s1_cmd;
  logic [IDX_W-1:0]           s1_idx;
  logic [gha_pkg::HGEN_W-1:0] s1_hgen;

  // Forwarding from the word ahead.
  logic              fwd_slot_hit;
  logic [SLOT_W-1:0] fwd_slot_data;
  logic              top_from_push;
  logic              top_from_below;
  logic [STK_W-1:0]  fwd_stk_data;

  // RAM ports.
  logic [SLOT_W-1:0] slot_rdata;
  logic              slot_we;
  logic [IDX_W-1:0]  slot_waddr;
  logic [SLOT_W-1:0] slot_wdata;
  logic [STK_W-1:0]  stk_rdata_top;
  logic [STK_W-1:0]  stk_rdata_below;
  logic              stk_we;
  logic [STK_W-1:0]  stk_wdata;
  logic [CNT_W-1:0]  stk_addr_top;
  logic [CNT_W-1:0]  stk_addr_below;

  // Execute-stage operands and decision.
  logic [SLOT_W-1:0]   slot_cur;
  logic [STK_W-1:0]    top_cur;
  logic [IDX_W-1:0]    top_idx;
  logic [GEN_BITS-1:0] top_gen;
  logic [GEN_BITS-1:0] new_gen;
  logic [GEN_BITS-1:0] alloc_gen;
  logic                alloc_ok;
  gha_pkg::gha_ctrl_t  ctrl;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Read the stack at the committed top and one below; the execute stage picks
  // whichever matches what the word ahead did to the count.
  assign stk_addr_top   = cnt - CNT_W'(1);
  assign stk_addr_below = cnt - CNT_W'(2);

  gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (handle_index),
    .rdata (slot_rdata)
  );

  gha_ram #(.WIDTH(STK_W), .DEPTH(SLOT_COUNT)) u_stk_ram_top (
    .clk   (clk),
    .we    (stk_we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata (stk_wdata),
    .raddr (stk_addr_top[IDX_W-1:0]),
    .rdata (stk_rdata_top)
  );

  // Second copy of the free stack gives the read one entry below the top.
  gha_ram #(.WIDTH(STK_W), .DEPTH(SLOT_COUNT)) u_stk_ram_below (
    .clk   (clk),
    .we    (stk_we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata (stk_wdata),
    .raddr (stk_addr_below[IDX_W-1:0]),
    .rdata (stk_rdata_below)
  );

  // Pick the live operands: forwarded data wins over the RAM read.
  assign slot_cur = fwd_slot_hit ? fwd_slot_data : slot_rdata;
  assign top_cur  = top_from_push  ? fwd_stk_data :
                    top_from_below ? stk_rdata_below : stk_rdata_top;
  assign top_idx  = top_cur[STK_W-1:GEN_BITS];
  assign top_gen  = top_cur[GEN_BITS-1:0];

  gha_exec #(.SLOT_COUNT(SLOT_COUNT), .GEN_BITS(GEN_BITS)) u_exec (
    .cmd        (s1_cmd),
    .idx        (s1_idx),
    .hgen       (s1_hgen),
    .slot_live  (slot_cur[GEN_BITS]),
    .slot_gen   (slot_cur[GEN_BITS-1:0]),
    .cnt        (cnt),
    .next_fresh (next_fresh),
    .ctrl       (ctrl),
    .new_gen    (new_gen)
  );

  // A fresh slot starts at generation one; a popped slot carries its generation
  // on the stack, so allocate never reads the slot RAM.
  assign alloc_ok  = ctrl.pop || ctrl.fresh;
  assign alloc_gen = ctrl.pop ? top_gen : GEN_BITS'(1);

  assign slot_we    = s1_valid && ctrl.slot_we;
  assign slot_waddr = ctrl.pop   ? top_idx :
                      ctrl.fresh ? next_fresh[IDX_W-1:0] : s1_idx;
  assign slot_wdata = {ctrl.slot_live, alloc_ok ? alloc_gen : new_gen};

  assign stk_we    = s1_valid && ctrl.push;
  assign stk_wdata = {s1_idx, new_gen};

  always_comb begin
    cnt_next        = cnt;
    next_fresh_next = next_fresh;
    if (s1_valid) begin
      if (ctrl.push) begin
        cnt_next = cnt + CNT_W'(1);
      end else if (ctrl.pop) begin
        cnt_next = cnt - CNT_W'(1);
      end
      if (ctrl.fresh) begin
        next_fresh_next = next_fresh + CNT_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt            <= '0;
      next_fresh     <= CNT_W'(1);
      s1_valid       <= 1'b0;
      fwd_slot_hit   <= 1'b0;
      top_from_push  <= 1'b0;
      top_from_below <= 1'b0;
      done           <= 1'b0;
    end else begin
      cnt            <= cnt_next;
      next_fresh     <= next_fresh_next;
      s1_valid       <= accept;
      // Hold the slot write if the word now being read hits the same slot.
      fwd_slot_hit   <= slot_we && (slot_waddr == handle_index);
      top_from_push  <= s1_valid && ctrl.push;
      top_from_below <= s1_valid && ctrl.pop;
      done           <= s1_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_cmd        <= command;
    s1_idx        <= handle_index;
    s1_hgen       <= handle_generation;
    fwd_slot_data <= slot_wdata;
    fwd_stk_data  <= stk_wdata;
    status        <= ctrl.status;
    is_alive      <= ctrl.alive;
    out_index     <= alloc_ok ? slot_waddr : '0;
    out_generation <= alloc_ok ? gha_pkg::HGEN_W'(alloc_gen) : '0;
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for generational_handle_allocator_core: a scoreboard class
// predicts every result word from its own copy of the slot map. Depends on gha_pkg and the core.

class slot_map_scoreboard;
  localparam int SLOTS = gha_pkg::SLOT_COUNT_DEF;
  localparam int GEN_W = gha_pkg::GEN_BITS_DEF;
  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [63:0] GEN_MASK = (64'd1 << GEN_W) - 64'd1;

  typedef struct {
    logic [gha_pkg::STATUS_W-1:0] status;
    logic [IDX_W-1:0]             slot_index;
    logic [gha_pkg::HGEN_W-1:0]   generation;
    logic                         alive;
  } result_word_t;

  bit                         live_mark  [SLOTS];
  logic [gha_pkg::HGEN_W-1:0] slot_gen   [SLOTS];
  logic [IDX_W-1:0]           free_stack [SLOTS];
  int unsigned                free_count;
  int unsigned                fresh_index;
  result_word_t               expected_words[$];
  int                         errors;

  function new();
    for (int i = 0; i < SLOTS; i++) begin
      live_mark[i]  = 1'b0;
      slot_gen[i]   = 1;
      free_stack[i] = '0;
    end
    free_count  = 0;
    fresh_index = 1;
    errors      = 0;
  endfunction

  function bit handle_live(int unsigned idx, logic [gha_pkg::HGEN_W-1:0] gen);
    if (idx == 0 || idx >= fresh_index || idx >= SLOTS) return 1'b0;
    return live_mark[idx] && (slot_gen[idx] == gen);
  endfunction

  // Predict the result of one accepted command word and advance the slot map.
  function void note_command(logic [gha_pkg::CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                             logic [gha_pkg::HGEN_W-1:0] gen);
    result_word_t w;
    int unsigned  slot;
    bit           got;
    logic [63:0]  sum;
    w.status     = gha_pkg::ST_INVALID;
    w.slot_index = '0;
    w.generation = '0;
    w.alive      = 1'b0;
    case (cmd)
      gha_pkg::CMD_ALLOC: begin
        got  = 1'b0;
        slot = 0;
        if (free_count > 0) begin
          free_count--;
          slot = 32'(free_stack[free_count]);
          got  = (slot != 0) && (slot < SLOTS);
        end else if (fresh_index < SLOTS) begin
          slot = fresh_index;
          fresh_index++;
          got  = 1'b1;
        end
        if (got) begin
          live_mark[slot] = 1'b1;
          w.status        = gha_pkg::ST_OK;
          w.slot_index    = IDX_W'(slot);
          w.generation    = slot_gen[slot];
        end else
          w.status = gha_pkg::ST_FULL;
      end
      gha_pkg::CMD_CHECK: begin
        if (handle_live(32'(idx), gen)) begin
          w.status = gha_pkg::ST_OK;
          w.alive  = 1'b1;
        end
      end
      gha_pkg::CMD_RELEASE: begin
        if (handle_live(32'(idx), gen) && free_count < SLOTS) begin
          // Bump the generation, skipping zero on wrap.
          sum = ({32'd0, slot_gen[idx]} + 64'd1) & GEN_MASK;
          if (sum == 64'd0) sum = 64'd1;
          live_mark[idx]         = 1'b0;
          slot_gen[idx]          = sum[gha_pkg::HGEN_W-1:0];
          free_stack[free_count] = idx;
          free_count++;
          w.status = gha_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    expected_words = {expected_words, w};
  endfunction

  function int field_mismatch(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val === act_val) return 0;
    $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_val, act_val);
    return 1;
  endfunction

  // Compare one result word with the oldest prediction.
  function void check_result(logic [gha_pkg::STATUS_W-1:0] st, logic [IDX_W-1:0] idx,
                             logic [gha_pkg::HGEN_W-1:0] gen, logic alive);
    result_word_t w;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected result word: expected none actual status %0h index %0h",
               $time, st, idx);
      errors++;
      return;
    end
    w = expected_words.pop_front();
    errors += field_mismatch("status", 32'(w.status), 32'(st));
    errors += field_mismatch("out_index", 32'(w.slot_index), 32'(idx));
    errors += field_mismatch("out_generation", w.generation, gen);
    errors += field_mismatch("is_alive", 32'(w.alive), 32'(alive));
  endfunction
endclass

module tb;
  import gha_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // Cycles with no word taken and no result shown before the run is called hung.
  localparam int WATCHDOG_LIMIT = 500;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    command;
  logic [IDX_W-1:0]    handle_index;
  logic [HGEN_W-1:0]   handle_generation;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    out_index;
  logic [HGEN_W-1:0]   out_generation;
  logic                is_alive;

  slot_map_scoreboard sb;
  bit                 gaps_on;
  int                 quiet_cycles = 0;

  generational_handle_allocator_core uut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .command           (command),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .done              (done),
    .status            (status),
    .out_index         (out_index),
    .out_generation    (out_generation),
    .is_alive          (is_alive)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample at the rising edge: check a shown result first, then note the word taken
  // at this edge. A result always belongs to an older word, so the order is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (done !== 1'b0) sb.check_result(status, out_index, out_generation, is_alive);
      if (start === 1'b1 && busy === 1'b0)
        sb.note_command(command, handle_index, handle_generation);
      if (done === 1'b1 || (start === 1'b1 && busy === 1'b0)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // Drive one command word at the falling edge and hold it until it is taken.
  // Drop start for random cycles first when gaps are enabled.
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                           logic [HGEN_W-1:0] gen);
    while (gaps_on && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start             <= 1'b1;
    command           <= cmd;
    handle_index      <= idx;
    handle_generation <= gen;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Pick a handle, mostly a live one with its current generation, sometimes off by
  // one generation, a random generation or a random index.
  task automatic pick_handle(output logic [IDX_W-1:0] idx, output logic [HGEN_W-1:0] gen);
    int unsigned slot;
    int          r;
    slot = $urandom_range(0, SLOTS - 1);
    if (sb.fresh_index > 1) begin
      for (int tries = 0; tries < 8; tries++) begin
        slot = $urandom_range(1, sb.fresh_index - 1);
        if (sb.live_mark[slot]) break;
      end
    end
    idx = IDX_W'(slot);
    gen = sb.slot_gen[slot];
    r   = $urandom_range(0, 99);
    if (r < 10) gen = gen + 1;
    else if (r < 20) gen = gen - 1;
    else if (r < 28) gen = $urandom;
    else if (r < 33) idx = IDX_W'($urandom);
  endtask

  // One random word; the remainder beyond the three shares is noise of any command.
  task automatic random_word(int alloc_pct, int release_pct, int check_pct);
    logic [IDX_W-1:0]  idx;
    logic [HGEN_W-1:0] gen;
    int                r;
    r = $urandom_range(0, 99);
    if (r < alloc_pct)
      send_word(CMD_ALLOC, IDX_W'($urandom), $urandom);
    else if (r < alloc_pct + release_pct) begin
      pick_handle(idx, gen);
      send_word(CMD_RELEASE, idx, gen);
    end else if (r < alloc_pct + release_pct + check_pct) begin
      pick_handle(idx, gen);
      send_word(CMD_CHECK, idx, gen);
    end else
      send_word(CMD_W'($urandom), IDX_W'($urandom), $urandom);
  endtask

  // Hold start low until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    sb                = new();
    rst               = 1'b1;
    start             = 1'b0;
    command           = CMD_ALLOC;
    handle_index      = '0;
    handle_generation = '0;
    gaps_on           = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words, back to back so the forwarding path sees dependent pairs.
    send_word(CMD_CHECK, '0, 32'd1);                 // null index
    send_word(CMD_RELEASE, '0, 32'd1);
    send_word(CMD_CHECK, IDX_W'(5), 32'd1);          // never-used index
    send_word(CMD_RELEASE, '1, 32'd1);
    send_word(CMD_ALLOC, '1, '1);                    // fresh slot 1
    send_word(CMD_CHECK, IDX_W'(1), 32'd1);
    send_word(CMD_CHECK, IDX_W'(1), '1);             // stale generation
    send_word(CMD_RELEASE, IDX_W'(1), 32'd2);
    send_word(CMD_RELEASE, IDX_W'(1), 32'd1);
    send_word(CMD_CHECK, IDX_W'(1), 32'd1);          // dead slot
    send_word(CMD_RELEASE, IDX_W'(1), 32'd1);        // double release
    send_word(CMD_ALLOC, '0, '0);                    // reuse slot 1, generation 2
    send_word(CMD_ALLOC, '0, '0);
    send_word(CMD_ALLOC, '0, '0);
    send_word(CMD_RELEASE, IDX_W'(2), 32'd1);
    send_word(CMD_RELEASE, IDX_W'(3), 32'd1);
    send_word(CMD_ALLOC, '0, '0);                    // LIFO: slot 3 first
    send_word(CMD_ALLOC, '0, '0);
    send_word(CMD_CHECK, IDX_W'(1), 32'h8000_0002);  // high generation bit set
    send_word(CMD_CHECK, IDX_W'(1), 32'd2);
    send_word(CMD_UNUSED, '1, '1);
    send_word(CMD_UNUSED, '0, '0);

    // Mixed random traffic with gaps.
    gaps_on = 1'b1;
    repeat (60) random_word(40, 30, 25);
    drain_results();

    // Fill the pool to exhaustion, then probe the full answer and the top slot.
    while (!(sb.fresh_index == SLOTS && sb.free_count == 0)) random_word(96, 2, 2);
    repeat (4) send_word(CMD_ALLOC, IDX_W'($urandom), $urandom);
    send_word(CMD_CHECK, '1, sb.slot_gen[SLOTS-1]);
    send_word(CMD_RELEASE, '1, sb.slot_gen[SLOTS-1]);
    send_word(CMD_ALLOC, '0, '0);
    send_word(CMD_ALLOC, '0, '0);

    // Long stretch with no gaps, release heavy to work the free stack.
    gaps_on = 1'b0;
    repeat (100) random_word(25, 55, 15);

    drain_results();
    repeat (4) @(posedge clk);
    if (sb.errors == 0)
      $display("generational_handle_allocator_core test passed");
    else
      $display("generational_handle_allocator_core test failed");
    $finish;
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("generational_handle_allocator_core test failed");
    $finish;
  end
endmodule
